[hw/rtl/reply_packet_deframer_core_assert.svh]
// assertion macros for the reply packet deframer
// each check is sampled on clk and held off while rst_n is low
`ifndef REPLY_PACKET_DEFRAMER_CORE_ASSERT_SVH
`define REPLY_PACKET_DEFRAMER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// condition must hold at every edge out of reset
`define RPD_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// antecedent at one edge implies consequent at the next
`define RPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define RPD_ASSERT_ALWAYS(lbl, cond)
`define RPD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[hw/rtl/rpd_pkg.sv]
// ----------------------------------------------------------------------------
// rpd_pkg
// Shared constants for the reply packet deframer: start code, frame layout
// and result kind codes.
// ----------------------------------------------------------------------------
package rpd_pkg;

  // default frame size limit in bytes
  localparam int MAX_FRAME_DEF = 64;

  // start code
  localparam logic [7:0] START_HI = 8'hEF;
  localparam logic [7:0] START_LO = 8'h01;

  // frame layout
  localparam int HEADER_BYTES   = 9;
  localparam int CHECKSUM_BYTES = 2;
  localparam int POS_FIRST      = 2;  // position after the start code
  localparam int POS_SUM_START  = 6;  // packet id, first summed byte
  localparam int POS_LEN_HI     = 7;
  localparam int POS_LEN_LO     = 8;

  // result field widths
  localparam int KIND_W = 2;
  localparam int BYTE_W = 8;
  localparam int PLEN_W = 6;

  typedef logic [KIND_W-1:0] kind_t;

  // result kinds
  localparam kind_t KIND_PAYLOAD  = 2'd0;
  localparam kind_t KIND_GOOD     = 2'd1;
  localparam kind_t KIND_CSUM_ERR = 2'd2;
  localparam kind_t KIND_LEN_ERR  = 2'd3;

endpackage

[hw/rtl/reply_packet_deframer_core.sv]
// ----------------------------------------------------------------------------
// reply_packet_deframer_core
// Byte-serial deframer for reply packets: start code, address, id, length,
// payload and a 16-bit additive checksum.
// ----------------------------------------------------------------------------
// Usage
//   in_valid/in_ready/in_rx_byte carry one received byte per beat.
//   out_valid/out_ready carry results: out_kind, out_byte, out_payload_len.
//   Each payload byte comes out as a payload beat as it arrives; the last
//   checksum byte gives a frame good beat (with payload length) or a
//   checksum error beat. A length field below 2 or above MAX_FRAME - 9 gives
//   a length error beat on the low length byte and hunting restarts.
//   Bytes that cause no result (hunting, header, high checksum) give no beat.
// Timing
//   One byte is taken every cycle while in_ready is high. A result appears
//   in the output register in the cycle after its byte is taken; the whole
//   step is a single pass of compare and 16-bit add logic on the frame state.
//   in_ready is high while the output register is empty or being drained,
//   so a stalled receiver holds off input only when a result is waiting.
// Reset
//   rst_n low returns the block to hunting for the start code, clears the
//   frame state and drops any pending result.
// ----------------------------------------------------------------------------
module reply_packet_deframer_core
  import rpd_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output kind_t             out_kind,
  output logic [BYTE_W-1:0] out_byte,
  output logic [PLEN_W-1:0] out_payload_len
);

`include "reply_packet_deframer_core_assert.svh"

  localparam int IDXW = $clog2(MAX_FRAME);
  localparam logic [15:0] LEN_MAX = 16'(MAX_FRAME - HEADER_BYTES);
  localparam logic [15:0] LEN_MIN = 16'(CHECKSUM_BYTES);

  // phase codes
  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_SYNC = 2'd1;
  localparam logic [1:0] PH_HDR  = 2'd2;
  localparam logic [1:0] PH_BODY = 2'd3;

  logic [1:0]        phase_r, phase_nxt;
  logic [IDXW-1:0]   byte_index_r, byte_index_nxt;
  logic [15:0]       frame_length_r, frame_length_nxt;
  logic [15:0]       running_sum_r, running_sum_nxt;
  logic [7:0]        checksum_high_r, checksum_high_nxt;

  logic              out_valid_r, out_valid_nxt;
  kind_t             out_kind_r, out_kind_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic [PLEN_W-1:0] out_plen_r, out_plen_nxt;

  logic              in_fire;
  logic              res_emit;
  logic [15:0]       plen;
  logic [15:0]       pos;
  logic [15:0]       sum_add;
  logic [15:0]       len_full;

  // input side runs whenever the result register is free or draining
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign plen     = frame_length_r - LEN_MIN;
  assign pos      = 16'(byte_index_r);
  assign sum_add  = running_sum_r + {8'h00, in_rx_byte};
  assign len_full = frame_length_r | {8'h00, in_rx_byte};

  // per-byte frame step
  always_comb begin
    phase_nxt         = phase_r;
    byte_index_nxt    = byte_index_r;
    frame_length_nxt  = frame_length_r;
    running_sum_nxt   = running_sum_r;
    checksum_high_nxt = checksum_high_r;
    res_emit          = 1'b0;
    out_kind_nxt      = KIND_PAYLOAD;
    out_byte_nxt      = '0;
    out_plen_nxt      = '0;
    case (phase_r)
      PH_HUNT: begin
        if (in_rx_byte == START_HI) begin
          phase_nxt = PH_SYNC;
        end
      end
      PH_SYNC: begin
        if (in_rx_byte == START_LO) begin
          phase_nxt        = PH_HDR;
          byte_index_nxt   = IDXW'(POS_FIRST);
          running_sum_nxt  = '0;
          frame_length_nxt = '0;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_HDR: begin
        if (byte_index_r >= IDXW'(POS_SUM_START)) begin
          running_sum_nxt = sum_add;
        end
        if (byte_index_r == IDXW'(POS_LEN_HI)) begin
          frame_length_nxt = {in_rx_byte, 8'h00};
        end
        if (byte_index_r == IDXW'(POS_LEN_LO)) begin
          frame_length_nxt = len_full;
          byte_index_nxt   = '0;
          if (len_full < LEN_MIN || len_full > LEN_MAX) begin
            phase_nxt    = PH_HUNT;
            res_emit     = 1'b1;
            out_kind_nxt = KIND_LEN_ERR;
          end else begin
            phase_nxt = PH_BODY;
          end
        end else begin
          byte_index_nxt = byte_index_r + 1'b1;
        end
      end
      PH_BODY: begin
        byte_index_nxt = byte_index_r + 1'b1;
        if (pos < plen) begin
          // payload byte, summed and passed on
          running_sum_nxt = sum_add;
          res_emit        = 1'b1;
          out_kind_nxt    = KIND_PAYLOAD;
          out_byte_nxt    = in_rx_byte;
        end else if (pos == plen) begin
          checksum_high_nxt = in_rx_byte;
        end else begin
          // low checksum byte closes the frame
          phase_nxt      = PH_HUNT;
          byte_index_nxt = '0;
          res_emit       = 1'b1;
          if ({checksum_high_r, in_rx_byte} == running_sum_r) begin
            out_kind_nxt = KIND_GOOD;
            out_plen_nxt = plen[PLEN_W-1:0];
          end else begin
            out_kind_nxt = KIND_CSUM_ERR;
          end
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  // result register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire && res_emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  // frame state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_HUNT;
      byte_index_r    <= '0;
      frame_length_r  <= '0;
      running_sum_r   <= '0;
      checksum_high_r <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        phase_r         <= phase_nxt;
        byte_index_r    <= byte_index_nxt;
        frame_length_r  <= frame_length_nxt;
        running_sum_r   <= running_sum_nxt;
        checksum_high_r <= checksum_high_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire && res_emit) begin
      out_kind_r <= out_kind_nxt;
      out_byte_r <= out_byte_nxt;
      out_plen_r <= out_plen_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_byte        = out_byte_r;
  assign out_payload_len = out_plen_r;

  // checks
  `RPD_ASSERT_ALWAYS(a_byte_zero, !out_valid_r || out_kind_r == KIND_PAYLOAD || out_byte_r == '0)
  `RPD_ASSERT_ALWAYS(a_plen_zero, !out_valid_r || out_kind_r == KIND_GOOD || out_plen_r == '0)
  `RPD_ASSERT_ALWAYS(a_hunt_idx, phase_r != PH_HUNT || byte_index_r == '0)
  `RPD_ASSERT_ALWAYS(a_body_idx, phase_r != PH_BODY || pos < frame_length_r)
  `RPD_ASSERT_NEXT(a_hunt_quiet, in_fire && phase_r == PH_HUNT, !out_valid_r)

endmodule
